FILE: src/epr_pkg.sv
// Shared constants for the echo pulse ranger: codes, register indexes, reset values, widths.
package epr_pkg;

    // Request kinds carried on s_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Completion status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_RISE  = 2'd1;
    localparam logic [1:0] STAT_ECHO_LONG = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_GUARD   = 2'd0;
    localparam logic [1:0] REG_PULSE   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_TPC     = 2'd3;

    // Register reset values
    localparam logic [15:0] GUARD_RST   = 16'd16;
    localparam logic [15:0] PULSE_RST   = 16'd192;
    localparam logic [23:0] TIMEOUT_RST = 24'd600000;
    localparam logic [15:0] TPC_RST     = 16'd928;

    // Field and bus widths
    localparam int DIST_W     = 24;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

FILE: src/echo_pulse_ranger.sv
// Ultrasonic echo pulse range meter: trigger sequencer, echo timer and serial divider.
//
// Usage: each transfer on the s_ channel is one item. s_tuser = 1 starts a measurement,
// s_tuser = 0 is one clock tick with the sampled echo pin level in s_tdata[0]. Every item
// gives exactly one result transfer on the m_ channel: the trigger pin level, busy, done,
// status and the distance in centimetres. The cfg_ channel writes the four timing
// registers (guard, pulse, timeout, ticks per cm); write them only while no measurement
// runs. cfg_ready is always high.
// Throughput: the result is registered and appears in the cycle after the input transfer.
// One item per cycle is taken as long as the receiver takes results. The item on which
// the echo falls is the exception: its distance comes from a restoring divider that
// settles one quotient bit per cycle, and s_tready stays low until that result is
// registered. A zero divisor skips the divider and reports all ones.
// Reset: aresetn low (synchronous) loads the register reset values, parks the measurement
// in idle and empties the output register.
// Stall: a result held in the output register stays until m_tready; s_tready drops while
// the output register is full and not being taken, so no result is lost.
module echo_pulse_ranger #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [epr_pkg::S_TDATA_W-1:0]      s_tdata,   // [0] echo_level, [7:1] zero
    input  logic                               s_tuser,   // [0] req_type
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [epr_pkg::M_TDATA_W-1:0]      m_tdata,   // [0] trigger_level, [1] busy_res,
                                                          // [2] done_res, [4:3] status,
                                                          // [28:5] distance_cm, [31:29] zero
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [epr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int EXT_W = (COUNT_WIDTH > epr_pkg::DIST_W) ? COUNT_WIDTH : epr_pkg::DIST_W;
    localparam int CNT_W = $clog2(COUNT_WIDTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_LOW,
        PH_HIGH,
        PH_POST_LOW,
        PH_WAIT_RISE,
        PH_ECHO_HIGH
    } phase_t;

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } state_t;

    // configuration
    logic [15:0] guard_reg;
    logic [15:0] pulse_reg;
    logic [23:0] timeout_reg;
    logic [15:0] tpc_reg;

    // measurement state
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] phase_ticks_reg, phase_ticks_next;
    logic [COUNT_WIDTH-1:0] echo_ticks_reg, echo_ticks_next;

    // sequencer and divider
    state_t                 state_reg, state_next;
    logic [15:0]            rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]       div_cnt_reg, div_cnt_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [epr_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // per-item decode
    phase_t                 ph;
    logic [COUNT_WIDTH-1:0] pt;
    logic [COUNT_WIDTH-1:0] et;
    logic                   res_trig;
    logic                   res_busy;
    logic                   res_done;
    logic [1:0]             res_status;
    logic                   dist_sat;
    logic                   div_start;

    // divider step
    logic [16:0] rem_shift;
    logic        rem_ge;
    logic [epr_pkg::DIST_W-1:0] quot_sat;

    logic in_xfer;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_RUN) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Work out what one accepted item does to the measurement.
    always_comb begin
        ph         = phase_reg;
        pt         = phase_ticks_reg;
        et         = echo_ticks_reg;
        res_trig   = 1'b0;
        res_busy   = 1'b0;
        res_done   = 1'b0;
        res_status = epr_pkg::STAT_OK;
        dist_sat   = 1'b0;
        div_start  = 1'b0;
        if (s_tuser == epr_pkg::REQ_START) begin
            // a start while busy only reports busy and the current trigger level
            if (ph == PH_IDLE) begin
                ph = PH_PRE_LOW;
                pt = '0;
                et = '0;
            end
            res_trig = (ph == PH_HIGH);
            res_busy = 1'b1;
        end else if (ph != PH_IDLE) begin
            // advance past finished drive phases, zero-length ones included
            if (ph == PH_PRE_LOW && pt >= COUNT_WIDTH'(guard_reg)) begin
                ph = PH_HIGH;
                pt = '0;
            end
            if (ph == PH_HIGH && pt >= COUNT_WIDTH'(pulse_reg)) begin
                ph = PH_POST_LOW;
                pt = '0;
            end
            if (ph == PH_POST_LOW && pt >= COUNT_WIDTH'(guard_reg)) begin
                ph = PH_WAIT_RISE;
                pt = '0;
            end
            case (ph)
                PH_PRE_LOW, PH_HIGH, PH_POST_LOW: begin
                    res_trig = (ph == PH_HIGH);
                    res_busy = 1'b1;
                    pt = (&pt) ? pt : pt + 1'b1;
                end
                PH_WAIT_RISE: begin
                    if (s_tdata[0]) begin
                        ph = PH_ECHO_HIGH;
                        et = COUNT_WIDTH'(1);
                        if (timeout_reg == '0) begin
                            ph         = PH_IDLE;
                            res_done   = 1'b1;
                            res_status = epr_pkg::STAT_ECHO_LONG;
                        end else begin
                            res_busy = 1'b1;
                        end
                    end else begin
                        pt = (&pt) ? pt : pt + 1'b1;
                        if (EXT_W'(pt) > EXT_W'(timeout_reg)) begin
                            ph         = PH_IDLE;
                            res_done   = 1'b1;
                            res_status = epr_pkg::STAT_NO_RISE;
                        end else begin
                            res_busy = 1'b1;
                        end
                    end
                end
                PH_ECHO_HIGH: begin
                    if (s_tdata[0]) begin
                        et = (&et) ? et : et + 1'b1;
                        if (EXT_W'(et) > EXT_W'(timeout_reg)) begin
                            ph         = PH_IDLE;
                            res_done   = 1'b1;
                            res_status = epr_pkg::STAT_ECHO_LONG;
                        end else begin
                            res_busy = 1'b1;
                        end
                    end else begin
                        // echo fell: report distance
                        ph       = PH_IDLE;
                        res_done = 1'b1;
                        if (tpc_reg == '0) begin
                            dist_sat = 1'b1;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_shift = {rem_reg, quot_reg[COUNT_WIDTH-1]};
        rem_ge    = (rem_shift >= {1'b0, tpc_reg});
        quot_sat  = (EXT_W'(quot_reg) > EXT_W'(epr_pkg::DIST_MAX)) ?
                    epr_pkg::DIST_MAX : epr_pkg::DIST_W'(quot_reg);
    end

    // Sequencer next state.
    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        echo_ticks_next  = echo_ticks_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        div_cnt_next     = div_cnt_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        case (state_reg)
            ST_RUN: begin
                if (in_xfer) begin
                    phase_next       = ph;
                    phase_ticks_next = pt;
                    echo_ticks_next  = et;
                    if (div_start) begin
                        // hold the result until the quotient settles
                        state_next   = ST_DIV;
                        quot_next    = et;
                        rem_next     = '0;
                        div_cnt_next = CNT_W'(COUNT_WIDTH);
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_data_next[0]   = res_trig;
                        m_data_next[1]   = res_busy;
                        m_data_next[2]   = res_done;
                        m_data_next[4:3] = res_status;
                        m_data_next[28:5] = dist_sat ? epr_pkg::DIST_MAX : '0;
                    end
                end
            end
            ST_DIV: begin
                if (div_cnt_reg != '0) begin
                    rem_next     = rem_ge ? 16'(rem_shift - {1'b0, tpc_reg}) : rem_shift[15:0];
                    quot_next    = {quot_reg[COUNT_WIDTH-2:0], rem_ge};
                    div_cnt_next = div_cnt_reg - 1'b1;
                end else if (!m_valid_reg || m_tready) begin
                    state_next        = ST_RUN;
                    m_valid_next      = 1'b1;
                    m_data_next       = '0;
                    m_data_next[2]    = 1'b1;
                    m_data_next[4:3]  = epr_pkg::STAT_OK;
                    m_data_next[28:5] = quot_sat;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_RUN;
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            echo_ticks_reg  <= '0;
            m_valid_reg     <= 1'b0;
            guard_reg       <= epr_pkg::GUARD_RST;
            pulse_reg       <= epr_pkg::PULSE_RST;
            timeout_reg     <= epr_pkg::TIMEOUT_RST;
            tpc_reg         <= epr_pkg::TPC_RST;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            echo_ticks_reg  <= echo_ticks_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    epr_pkg::REG_GUARD:   guard_reg   <= cfg_data[15:0];
                    epr_pkg::REG_PULSE:   pulse_reg   <= cfg_data[15:0];
                    epr_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[23:0];
                    epr_pkg::REG_TPC:     tpc_reg     <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        div_cnt_reg <= div_cnt_next;
        m_data_reg  <= m_data_next;
    end

`ifndef SYNTH
    // a measurement is finished before its quotient is worked out
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> phase_reg == PH_IDLE)
        else $error("divider running while a measurement is active");

    // a completed measurement is never reported as busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("result flags busy and done together");

    // an error status only appears on a completion, without a distance
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:3] != epr_pkg::STAT_OK |-> m_tdata[2] && m_tdata[28:5] == '0)
        else $error("error status outside a completion");

    // starting the divider always leaves the result pending for the quotient
    a_div_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN && state_next == ST_DIV |=> !m_tvalid)
        else $error("result shown while the divider starts");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the ultrasonic echo pulse range meter.
`timescale 1ns / 100ps

module tb_top;

    localparam int COUNT_W    = 24;
    // Settle wait: long enough for the serial divider on the echo-fall item, plus margin.
    localparam int LAT_CYCLES = COUNT_W + 8;

    // Measurement sequencing as the predictor tracks it
    typedef enum logic [2:0] {
        MS_IDLE,
        MS_PRE_GUARD,
        MS_PULSE,
        MS_POST_GUARD,
        MS_AWAIT_ECHO,
        MS_ECHO
    } meas_phase_t;

    // One result transfer, unpacked
    typedef struct packed {
        logic                       trig;
        logic                       busy;
        logic                       done;
        logic [1:0]                 status;
        logic [epr_pkg::DIST_W-1:0] dist_cm;
    } reading_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [epr_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            s_tuser = epr_pkg::REQ_TICK;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [epr_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index = epr_pkg::REG_GUARD;
    logic [epr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor copy of the timing registers
    logic [15:0]            cfg_guard   = epr_pkg::GUARD_RST;
    logic [15:0]            cfg_pulse   = epr_pkg::PULSE_RST;
    logic [23:0]            cfg_timeout = epr_pkg::TIMEOUT_RST;
    logic [15:0]            cfg_tpc     = epr_pkg::TPC_RST;

    // Predictor copy of the measurement state
    meas_phase_t            meas_phase = MS_IDLE;
    logic [COUNT_W-1:0]     phase_cnt  = '0;
    logic [COUNT_W-1:0]     echo_cnt   = '0;

    reading_t               expected_readings[$];
    reading_t               want;

    int unsigned            s_idle_pct = 23;
    int unsigned            m_idle_pct = 70;
    int unsigned            items_sent = 0;
    int unsigned            readings_seen = 0;
    int unsigned            ranges_ok = 0;
    int unsigned            no_rise_seen = 0;
    int unsigned            echo_long_seen = 0;
    int unsigned            mismatches = 0;

    echo_pulse_ranger #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [0] echo_level, [7:1] zero
        .s_tuser  (s_tuser),    // [0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [0] trigger, [1] busy, [2] done, [4:3] status,
                                // [28:5] distance_cm, [31:29] zero
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Receiver: stall at random, change only on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Counters stick at all ones instead of wrapping.
    function automatic logic [COUNT_W-1:0] count_sat(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the measurement by one item and return the reading it yields.
    function automatic reading_t predict_reading(input logic start, input logic echo);
        reading_t    r;
        logic [15:0] len;
        r = '0;
        if (start) begin
            // A start while busy leaves everything alone and consumes no tick.
            if (meas_phase == MS_IDLE) begin
                meas_phase = MS_PRE_GUARD;
                phase_cnt  = '0;
                echo_cnt   = '0;
            end
            r.trig = (meas_phase == MS_PULSE);
            r.busy = 1'b1;
            return r;
        end
        if (meas_phase == MS_IDLE)
            return r;

        // Step past finished drive phases; zero-length ones fall straight through.
        while (meas_phase inside {MS_PRE_GUARD, MS_PULSE, MS_POST_GUARD}) begin
            len = (meas_phase == MS_PULSE) ? cfg_pulse : cfg_guard;
            if (phase_cnt < len)
                break;
            case (meas_phase)
                MS_PRE_GUARD: meas_phase = MS_PULSE;
                MS_PULSE:     meas_phase = MS_POST_GUARD;
                default:      meas_phase = MS_AWAIT_ECHO;
            endcase
            phase_cnt = '0;
        end

        case (meas_phase)
            MS_PRE_GUARD, MS_PULSE, MS_POST_GUARD: begin
                r.trig    = (meas_phase == MS_PULSE);
                r.busy    = 1'b1;
                phase_cnt = count_sat(phase_cnt);
            end
            MS_AWAIT_ECHO: begin
                if (echo) begin
                    meas_phase = MS_ECHO;
                    echo_cnt   = COUNT_W'(1);
                    if (echo_cnt > cfg_timeout) begin
                        meas_phase = MS_IDLE;
                        r.done     = 1'b1;
                        r.status   = epr_pkg::STAT_ECHO_LONG;
                    end else begin
                        r.busy = 1'b1;
                    end
                end else begin
                    phase_cnt = count_sat(phase_cnt);
                    if (phase_cnt > cfg_timeout) begin
                        meas_phase = MS_IDLE;
                        r.done     = 1'b1;
                        r.status   = epr_pkg::STAT_NO_RISE;
                    end else begin
                        r.busy = 1'b1;
                    end
                end
            end
            default: begin
                if (echo) begin
                    echo_cnt = count_sat(echo_cnt);
                    if (echo_cnt > cfg_timeout) begin
                        meas_phase = MS_IDLE;
                        r.done     = 1'b1;
                        r.status   = epr_pkg::STAT_ECHO_LONG;
                    end else begin
                        r.busy = 1'b1;
                    end
                end else begin
                    // Echo fell: convert the high time to centimetres.
                    meas_phase = MS_IDLE;
                    r.done     = 1'b1;
                    r.status   = epr_pkg::STAT_OK;
                    r.dist_cm  = (cfg_tpc == 0) ? epr_pkg::DIST_MAX :
                                 epr_pkg::DIST_W'(echo_cnt / cfg_tpc);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each result transfer against the oldest pending reading.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual 0x%08h",
                         $time, m_tdata);
            end else begin
                want = expected_readings.pop_front();
                readings_seen++;
                if (want.done) begin
                    case (want.status)
                        epr_pkg::STAT_NO_RISE:   no_rise_seen++;
                        epr_pkg::STAT_ECHO_LONG: echo_long_seen++;
                        default:                 ranges_ok++;
                    endcase
                end
                check_field("trigger_level", want.trig, m_tdata[0]);
                check_field("busy_res", want.busy, m_tdata[1]);
                check_field("done_res", want.done, m_tdata[2]);
                check_field("status", want.status, m_tdata[4:3]);
                check_field("distance_cm", want.dist_cm, m_tdata[28:5]);
                check_field("pad bits", 0, m_tdata[31:29]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------

    // Offer one item, idling first at random; predict it once the transfer happens.
    task automatic send_item(input logic req, input logic echo);
        @(negedge aclk);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(epr_pkg::S_TDATA_W-1){1'b0}}, echo};
        do @(posedge aclk); while (!s_tready);
        expected_readings.push_back(predict_reading(req, echo));
        items_sent++;
    endtask

    // Hold the sender until every result is back and the divider has surely finished.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_readings.size() == 0);
        repeat (LAT_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [epr_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            epr_pkg::REG_GUARD:   cfg_guard   = val[15:0];
            epr_pkg::REG_PULSE:   cfg_pulse   = val[15:0];
            epr_pkg::REG_TIMEOUT: cfg_timeout = val[23:0];
            default:              cfg_tpc     = val[15:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Only call between phases: drains results first so the block is idle.
    task automatic set_timing(input int unsigned guard, input int unsigned pulse,
                              input int unsigned tmo, input int unsigned tpc);
        settle();
        write_reg(epr_pkg::REG_GUARD, epr_pkg::CFG_DATA_W'(guard));
        write_reg(epr_pkg::REG_PULSE, epr_pkg::CFG_DATA_W'(pulse));
        write_reg(epr_pkg::REG_TIMEOUT, epr_pkg::CFG_DATA_W'(tmo));
        write_reg(epr_pkg::REG_TPC, epr_pkg::CFG_DATA_W'(tpc));
    endtask

    // One measurement: start, trigger ticks (echo ignored there), a low wait,
    // a high echo and a falling tick. Stray starts land while busy at busy_pct.
    task automatic measure(input int unsigned wait_ticks, input int unsigned high_ticks,
                           input int unsigned busy_pct);
        int unsigned drive_n;
        drive_n = 2 * int'(cfg_guard) + int'(cfg_pulse);
        send_item(epr_pkg::REQ_START, 1'($urandom_range(1)));
        for (int i = 0; i < drive_n + wait_ticks + high_ticks; i++) begin
            if (meas_phase != MS_IDLE && $urandom_range(99) < busy_pct)
                send_item(epr_pkg::REQ_START, 1'($urandom_range(1)));
            if (i < drive_n)
                send_item(epr_pkg::REQ_TICK, 1'($urandom_range(1)));
            else
                send_item(epr_pkg::REQ_TICK, i >= drive_n + wait_ticks);
        end
        send_item(epr_pkg::REQ_TICK, 1'b0);
    endtask

    // Feed low ticks until the measurement ends on its own (timeout or fall).
    task automatic run_out();
        while (meas_phase != MS_IDLE)
            send_item(epr_pkg::REQ_TICK, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle ticks, then a full measurement on the reset timing values.
    task automatic test_reset_defaults();
        send_item(epr_pkg::REQ_TICK, 1'b0);
        send_item(epr_pkg::REQ_TICK, 1'b1);
        measure(3, 60, 0);
    endtask

    // Zero-length guard and pulse phases, including all of them skipped.
    task automatic test_drive_skip();
        set_timing(0, 0, 10, 2);
        measure(0, 4, 0);
        measure(3, 1, 0);
        set_timing(2, 0, 10, 2);
        measure(1, 3, 0);
        set_timing(0, 3, 10, 2);
        measure(0, 2, 0);
    endtask

    // Rise-wait and echo-high limits right at and just past the timeout.
    task automatic test_timeout_edges();
        set_timing(1, 1, 0, 1);
        measure(0, 1, 0);
        measure(1, 0, 0);
        set_timing(1, 2, 1, 1);
        measure(1, 1, 0);
        measure(2, 0, 0);
        measure(0, 2, 0);
        set_timing(1, 1, 5, 1);
        measure(5, 5, 0);
        measure(6, 0, 0);
        measure(0, 6, 0);
    endtask

    // Zero divisor, unit divisor, a remainder and the largest divisor.
    task automatic test_divider();
        set_timing(1, 1, 50, 0);
        measure(0, 7, 0);
        set_timing(1, 1, 50, 1);
        measure(0, 12, 0);
        set_timing(1, 1, 50, 5);
        measure(0, 14, 0);
        set_timing(1, 1, 50, 65535);
        measure(0, 3, 0);
    endtask

    // Starts arriving in every phase of a running measurement.
    task automatic test_busy_start();
        set_timing(3, 3, 20, 2);
        measure(4, 6, 60);
        measure(2, 9, 40);
    endtask

    // Well-formed measurements with random content on small random timing,
    // with some stray items in front of them.
    task automatic test_random_ranging(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned tmo;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            tmo = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 40);
            set_timing($urandom_range(0, 3), $urandom_range(0, 5), tmo, $urandom_range(0, 9));
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(99) < 15)
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
                if ($urandom_range(99) < 80)
                    measure($urandom_range(0, tmo), $urandom_range(1, tmo + 2), 8);
                else
                    measure(tmo + 1, $urandom_range(0, 3), 8);
            end
            run_out();
        end
    endtask

    // Largest timeout and divisor, then a long echo on a unit divisor.
    task automatic test_register_extremes();
        set_timing(0, 1, 16777215, 65535);
        measure(2, 100, 0);
        set_timing(0, 1, 16777215, 1);
        measure(2, 150, 0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles lightly, receiver stalls heavily.
        s_idle_pct = 23;
        m_idle_pct = 70;
        test_reset_defaults();
        test_drive_skip();
        test_timeout_edges();
        test_divider();
        test_busy_start();
        test_random_ranging(250);

        // Swap the pressure.
        settle();
        s_idle_pct = 70;
        m_idle_pct = 23;
        test_random_ranging(250);

        // Back to back with no idling at all.
        settle();
        s_idle_pct = 0;
        m_idle_pct = 0;
        test_random_ranging(250);
        test_register_extremes();

        settle();
        $display("Sent %0d items, checked %0d results: %0d ranges, %0d no-echo, %0d echo-too-long",
                 items_sent, readings_seen, ranges_ok, no_rise_seen, echo_long_seen);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", expected_readings.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/epr_pkg.sv
src/echo_pulse_ranger.sv
tb/tb_top.sv
